[sv/lifosrch_pkg.sv]
// shared types and constants for the lifo stack with depth-limited search
// no dependencies; imported by every module of the block
`default_nettype none

package lifosrch_pkg;

   // parameter defaults
   localparam int DEPTH_DEF      = 64;
   localparam int ITEM_WIDTH_DEF = 32;

   // fixed field widths of the channel words
   localparam int FIELD_W = 32;
   localparam int LIMIT_W = 8;

   // hit bits folded per cycle by the search scanner
   localparam int SCAN_CHUNK = 32;

   typedef enum logic [1:0] {
      FN_PUSH   = 2'd0,
      FN_POP    = 2'd1,
      FN_SEARCH = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_POP_EMPTY = 2'd1,
      ST_PUSH_FULL = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE = 2'b01,
      FSM_SCAN = 2'b10
   } fsm_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      logic push;
      logic pop;
      logic search;
   } cell_ctl_type;

   // scanner report
   typedef struct packed {
      logic done;
      logic found;
   } scan_res_type;

endpackage

`default_nettype wire

[sv/lifosrch_cell.sv]
// one stack cell: holds one entry, shifts with its neighbors, compares against a key
// depends on lifosrch_pkg
`default_nettype none

module lifosrch_cell #(
   parameter int ITEM_WIDTH = lifosrch_pkg::ITEM_WIDTH_DEF,
   parameter int IDX        = 0,
   parameter int CMP_W      = 7
) (
   input  wire logic                       clock,
   input  wire lifosrch_pkg::cell_ctl_type ctl,
   input  wire logic [ITEM_WIDTH-1:0]      above_val,
   input  wire logic [ITEM_WIDTH-1:0]      below_val,
   input  wire logic [ITEM_WIDTH-1:0]      key,
   input  wire logic [CMP_W-1:0]           checks,
   output logic      [ITEM_WIDTH-1:0]      val,
   output logic                            hit
);
   import lifosrch_pkg::*;

   logic [ITEM_WIDTH-1:0] val_ff, val_in;
   logic                  hit_ff, hit_in;
   logic                  in_range;

   // cell index counts down from the top of the stack
   assign in_range = CMP_W'(IDX) < checks;

   always_comb begin
      if (ctl.push) begin
         val_in = above_val;
      end else if (ctl.pop) begin
         val_in = below_val;
      end else begin
         val_in = val_ff;
      end
      hit_in = ctl.search ? (in_range && (val_ff == key)) : hit_ff;
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
      hit_ff <= hit_in;
   end

   assign val = val_ff;
   assign hit = hit_ff;

endmodule

`default_nettype wire

[sv/lifosrch_scan.sv]
// search scanner: folds the cells' hit bits into one found flag, a chunk per cycle
// depends on lifosrch_pkg
`default_nettype none

module lifosrch_scan #(
   parameter int DEPTH = lifosrch_pkg::DEPTH_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [DEPTH-1:0]           hits,
   output lifosrch_pkg::scan_res_type      res
);
   import lifosrch_pkg::*;

   localparam int CHUNK_W = (DEPTH < SCAN_CHUNK) ? DEPTH : SCAN_CHUNK;
   localparam int NCHUNK  = (DEPTH + CHUNK_W - 1) / CHUNK_W;
   localparam int IDX_W   = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
   localparam int PAD_W   = NCHUNK * CHUNK_W;

   logic               busy_ff, busy_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               acc_ff, acc_in;
   logic [PAD_W-1:0]   padded;
   logic [CHUNK_W-1:0] chunk;
   logic               last;

   assign padded = PAD_W'(hits);
   assign chunk  = padded[idx_ff*CHUNK_W +: CHUNK_W];
   assign last   = idx_ff == IDX_W'(NCHUNK - 1);

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         idx_in  = '0;
         acc_in  = 1'b0;
      end else if (busy_ff) begin
         busy_in = !last;
         idx_in  = idx_ff + IDX_W'(1);
         acc_in  = acc_ff | (|chunk);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      idx_ff <= idx_in;
      acc_ff <= acc_in;
   end

   assign res.done  = busy_ff && last;
   assign res.found = acc_ff | (|chunk);

endmodule

`default_nettype wire

[sv/lifo_stack_with_depth_search.sv]
// top level of the lifo stack with depth-limited search
// depends on lifosrch_pkg, lifosrch_cell and lifosrch_scan
//
// A last-in, first-out stack of DEPTH entries of ITEM_WIDTH bits, built as a
// row of cells where cell 0 always holds the top entry: a push shifts every
// cell down by one, a pop shifts every cell up by one. Each request word gives
// exactly one response word carrying the popped value, the search result, the
// empty flag, the count after the request and a status (ok, pop on empty,
// push on full; a refused request leaves the stack as it was). Push, pop and
// the unused code are settled at accept and can be accepted every
// cycle while the result slot is free. A search latches a masked compare in
// every cell in the accept cycle, then the scanner folds the hit bits 32 per
// cycle, and the block accepts nothing more until the scan is done. A
// negative search limit means the whole stack is checked. Responses pass
// through a result slot and an output register, so a finished word waiting
// on rsp_ready does not stall the next request. No clearing pass after reset.
`default_nettype none

module lifo_stack_with_depth_search #(
   parameter int DEPTH      = lifosrch_pkg::DEPTH_DEF,
   parameter int ITEM_WIDTH = lifosrch_pkg::ITEM_WIDTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [1:0]                        req_func,
   input  wire logic [lifosrch_pkg::FIELD_W-1:0]  req_item_value,
   input  wire logic [lifosrch_pkg::LIMIT_W-1:0]  req_search_limit,
   // response channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [lifosrch_pkg::FIELD_W-1:0]       rsp_popped_value,
   output logic                                   rsp_found,
   output logic                                   rsp_is_empty,
   output logic [$clog2(DEPTH+1)-1:0]             rsp_entry_total,
   output lifosrch_pkg::status_type               rsp_status
);
   import lifosrch_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > LIMIT_W - 1) ? CNT_W : LIMIT_W - 1;

   // handshake and decode
   logic accept;
   logic is_push, is_pop, is_srch;
   logic can_push, can_pop;

   // stack count
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // cell row
   cell_ctl_type          ctl;
   logic [ITEM_WIDTH-1:0] key;
   logic [ITEM_WIDTH+FIELD_W-1:0] key_wide;
   logic [CMP_W-1:0]      checks, lim_ext, cnt_ext;
   logic [ITEM_WIDTH-1:0] cell_val [DEPTH];
   logic [DEPTH-1:0]      cell_hit;
   logic [FIELD_W+ITEM_WIDTH-1:0] top_wide;
   logic [FIELD_W-1:0]    top_val;

   // scanner
   scan_res_type scan_res;

   // control
   fsm_type state_ff, state_in;

   // result slot between the core and the output register
   logic               dn_valid_ff, dn_valid_in;
   logic [FIELD_W-1:0] dn_popped_ff, dn_popped_in;
   logic               dn_found_ff, dn_found_in;
   logic               dn_empty_ff, dn_empty_in;
   logic [CNT_W-1:0]   dn_total_ff, dn_total_in;
   status_type         dn_status_ff, dn_status_in;
   logic               fill, move, done_free;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [FIELD_W-1:0] rsp_popped_ff;
   logic               rsp_found_ff;
   logic               rsp_empty_ff;
   logic [CNT_W-1:0]   rsp_total_ff;
   status_type         rsp_status_ff;

   // ---------------------------------------------------------------- decode
   assign move      = dn_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign done_free = !dn_valid_ff || move;
   assign req_ready = (state_ff == FSM_IDLE) && done_free;
   assign accept    = req_valid && req_ready;

   assign is_push  = req_func == FN_PUSH;
   assign is_pop   = req_func == FN_POP;
   assign is_srch  = req_func == FN_SEARCH;
   assign can_push = cnt_ff != CNT_W'(DEPTH);
   assign can_pop  = cnt_ff != '0;

   assign ctl.push   = accept && is_push && can_push;
   assign ctl.pop    = accept && is_pop && can_pop;
   assign ctl.search = accept && is_srch;

   // word value masked or zero-extended to the entry width
   assign key_wide = {{ITEM_WIDTH{1'b0}}, req_item_value};
   assign key      = key_wide[ITEM_WIDTH-1:0];

   // entries to check: negative limit means all, else the smaller of limit and count
   assign lim_ext = CMP_W'(req_search_limit[LIMIT_W-2:0]);
   assign cnt_ext = CMP_W'(cnt_ff);
   assign checks  = req_search_limit[LIMIT_W-1] ? cnt_ext :
                    ((lim_ext < cnt_ext) ? lim_ext : cnt_ext);

   always_comb begin
      cnt_in = cnt_ff;
      if (ctl.push) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (ctl.pop) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   // ---------------------------------------------------------------- cell row
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [ITEM_WIDTH-1:0] above, below;
      if (i == 0) begin : g_top
         assign above = key;
      end else begin : g_mid
         assign above = cell_val[i-1];
      end
      if (i == DEPTH - 1) begin : g_bot
         assign below = cell_val[i];
      end else begin : g_nbot
         assign below = cell_val[i+1];
      end

      lifosrch_cell #(
         .ITEM_WIDTH (ITEM_WIDTH),
         .IDX        (i),
         .CMP_W      (CMP_W)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .above_val (above),
         .below_val (below),
         .key       (key),
         .checks    (checks),
         .val       (cell_val[i]),
         .hit       (cell_hit[i])
      );
   end

   // top entry resized to the word width for the popped value
   assign top_wide = {{FIELD_W{1'b0}}, cell_val[0]};
   assign top_val  = top_wide[FIELD_W-1:0];

   // ---------------------------------------------------------------- scanner
   lifosrch_scan #(
      .DEPTH (DEPTH)
   ) u_scan (
      .clock (clock),
      .reset (reset),
      .start (ctl.search),
      .hits  (cell_hit),
      .res   (scan_res)
   );

   // ---------------------------------------------------------------- control
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (ctl.search) begin
               state_in = FSM_SCAN;
            end
         end
         FSM_SCAN: begin
            if (scan_res.done) begin
               state_in = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------- result slot
   // push, pop and no-op fill the slot at accept; a search fills it when the scan ends
   assign fill = (accept && !is_srch) || scan_res.done;

   always_comb begin
      dn_popped_in = dn_popped_ff;
      dn_found_in  = dn_found_ff;
      dn_empty_in  = dn_empty_ff;
      dn_total_in  = dn_total_ff;
      dn_status_in = dn_status_ff;
      if (scan_res.done) begin
         dn_popped_in = '0;
         dn_found_in  = scan_res.found;
         dn_empty_in  = cnt_ff == '0;
         dn_total_in  = cnt_ff;
         dn_status_in = ST_OK;
      end else if (fill) begin
         dn_popped_in = ctl.pop ? top_val : '0;
         dn_found_in  = 1'b0;
         dn_empty_in  = cnt_in == '0;
         dn_total_in  = cnt_in;
         if (is_push && !can_push) begin
            dn_status_in = ST_PUSH_FULL;
         end else if (is_pop && !can_pop) begin
            dn_status_in = ST_POP_EMPTY;
         end else begin
            dn_status_in = ST_OK;
         end
      end

      if (fill) begin
         dn_valid_in = 1'b1;
      end else if (move) begin
         dn_valid_in = 1'b0;
      end else begin
         dn_valid_in = dn_valid_ff;
      end

      if (move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         cnt_ff       <= '0;
         dn_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         dn_valid_ff  <= dn_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dn_popped_ff <= dn_popped_in;
      dn_found_ff  <= dn_found_in;
      dn_empty_ff  <= dn_empty_in;
      dn_total_ff  <= dn_total_in;
      dn_status_ff <= dn_status_in;
      if (move) begin
         rsp_popped_ff <= dn_popped_ff;
         rsp_found_ff  <= dn_found_ff;
         rsp_empty_ff  <= dn_empty_ff;
         rsp_total_ff  <= dn_total_ff;
         rsp_status_ff <= dn_status_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_popped_value = rsp_popped_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_is_empty     = rsp_empty_ff;
   assign rsp_entry_total  = rsp_total_ff;
   assign rsp_status       = rsp_status_ff;

   // ---------------------------------------------------------------- checks
   // count stays within capacity
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(DEPTH))
      else $error("stack count above capacity");

   // no request taken while a search is being folded
   a_scan_block: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_SCAN) |-> !req_ready)
      else $error("request accepted during search scan");

   // scanner finishes only for a search in flight
   a_scan_owner: assert property (@(posedge clock) disable iff (reset)
      scan_res.done |-> (state_ff == FSM_SCAN))
      else $error("scan done outside search state");

   // a pending result word is never overwritten
   a_slot_free: assert property (@(posedge clock) disable iff (reset)
      fill |-> done_free)
      else $error("result slot overwritten");

   // a search leaves the count unchanged until its word is produced
   a_srch_cnt: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_SCAN) |=> $stable(cnt_ff))
      else $error("count changed during search");

endmodule

`default_nettype wire

[dv/tb.sv]
// testbench for lifo_stack_with_depth_search: push, pop and bounded search words
// checked against a shadow stack; depends on lifosrch_pkg and the block's rtl
`timescale 1ns / 100ps

module tb;
   import lifosrch_pkg::*;

   localparam int STACK_DEPTH = DEPTH_DEF;
   localparam int SH_IDX_W    = $clog2(STACK_DEPTH);
   // the one request code with no operation behind it
   localparam logic [1:0] FN_UNUSED = 2'd3;
   // search limit encodings
   localparam logic [7:0] LIM_NONE = 8'hFF;
   localparam logic [7:0] LIM_MOST_NEG = 8'h80;

   // one expected response word
   typedef struct {
      logic [31:0] popped;
      logic        found;
      logic        empty;
      logic [6:0]  total;
      status_type  status;
   } rsp_word_type;

   // clock and reset, all inputs known from time zero
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_func = FN_PUSH;
   logic [31:0] req_item_value = '0;
   logic [7:0]  req_search_limit = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_popped_value;
   logic        rsp_found;
   logic        rsp_is_empty;
   logic [6:0]  rsp_entry_total;
   status_type  rsp_status;

   // shadow copy of the stack, index 0 is the bottom entry
   logic [31:0]  shadow_stack [STACK_DEPTH];
   int           shadow_count = 0;
   rsp_word_type pending_rsp [$];

   int error_count = 0;
   int rsp_seen = 0;
   // idle rates in percent for sender and receiver
   int src_idle_pct = 30;
   int sink_idle_pct = 30;
   // receiver hold-off request, picked up by the receiver process
   int hold_request = 0;
   int hold_left = 0;

   always #6 clock = ~clock;

   lifo_stack_with_depth_search i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_item_value   (req_item_value),
      .req_search_limit (req_search_limit),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_popped_value (rsp_popped_value),
      .rsp_found        (rsp_found),
      .rsp_is_empty     (rsp_is_empty),
      .rsp_entry_total  (rsp_entry_total),
      .rsp_status       (rsp_status)
   );

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("tb: mismatch on word %0d, %s: got %h, expected %h", rsp_seen, what, got, want);
      error_count++;
   endtask

   // apply one accepted request word to the shadow stack and queue its response
   function automatic void predict_stack_op(logic [1:0] f, logic [31:0] v, logic [7:0] lim);
      rsp_word_type w;
      int           checks;
      w.popped = '0;
      w.found  = 1'b0;
      w.status = ST_OK;
      case (f)
         FN_PUSH: begin
            if (shadow_count >= STACK_DEPTH) begin
               w.status = ST_PUSH_FULL;
            end else begin
               shadow_stack[SH_IDX_W'(shadow_count)] = v;
               shadow_count++;
            end
         end
         FN_POP: begin
            if (shadow_count == 0) begin
               w.status = ST_POP_EMPTY;
            end else begin
               shadow_count--;
               w.popped = shadow_stack[SH_IDX_W'(shadow_count)];
            end
         end
         FN_SEARCH: begin
            // any negative limit means the whole stack, otherwise clip to the count
            checks = shadow_count;
            if (!lim[7] && int'(lim[6:0]) < checks) checks = int'(lim[6:0]);
            for (int k = 0; k < checks; k++) begin
               if (shadow_stack[SH_IDX_W'(shadow_count - 1 - k)] == v) w.found = 1'b1;
            end
         end
         default: ;
      endcase
      w.empty = (shadow_count == 0);
      w.total = shadow_count[6:0];
      pending_rsp.push_back(w);
   endfunction

   // offer one request word, hold it until taken, then predict its response;
   // entered and left just after a rising edge, valid stays high on return
   task automatic send_word(logic [1:0] f, logic [31:0] v, logic [7:0] lim);
      while ($urandom_range(99) < src_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_func         <= f;
      req_item_value   <= v;
      req_search_limit <= lim;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_stack_op(f, v, lim);
   endtask

   // sender goes quiet until every expected word has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   // one random word; push_bias sets how hard the mix leans toward filling
   task automatic send_random_op(int push_bias);
      int          pick;
      logic [1:0]  f;
      logic [31:0] v;
      logic [7:0]  lim;
      pick = $urandom_range(99);
      if (pick < 3) f = FN_UNUSED;
      else if (pick < 3 + push_bias) f = FN_PUSH;
      else if (pick < 3 + push_bias + (97 - push_bias) / 2) f = FN_POP;
      else f = FN_SEARCH;
      // small values give duplicates, so a search can hit above and below its limit
      case ($urandom_range(9))
         0: v = '0;
         1: v = '1;
         2, 3: v = $urandom_range(7);
         default: v = $urandom;
      endcase
      if (f == FN_SEARCH && shadow_count > 0 && $urandom_range(99) < 60)
         v = shadow_stack[SH_IDX_W'($urandom_range(shadow_count - 1))];
      case ($urandom_range(7))
         0: lim = LIM_NONE;
         1: lim = '0;
         2: lim = 8'($urandom_range(128, 255));
         3: lim = 8'($urandom_range(65, 127));
         default: lim = 8'($urandom_range(0, shadow_count + 1));
      endcase
      send_word(f, v, lim);
   endtask

   // requests on an empty stack: pop underflow, searches that see nothing, unused code
   task automatic test_empty_stack();
      send_word(FN_POP, 32'h0000_0000, 8'h00);
      send_word(FN_SEARCH, 32'h0000_0000, LIM_NONE);
      send_word(FN_SEARCH, 32'hFFFF_FFFF, 8'h00);
      send_word(FN_UNUSED, 32'hFFFF_FFFF, LIM_NONE);
   endtask

   // extreme values, every limit flavor against a four-deep stack, then unwind
   task automatic test_search_limits();
      send_word(FN_PUSH, 32'h0000_0000, 8'h00);
      send_word(FN_PUSH, 32'hFFFF_FFFF, 8'hFF);
      send_word(FN_PUSH, 32'hAAAA_AAAA, 8'h55);
      send_word(FN_PUSH, 32'h5555_5555, 8'hAA);
      send_word(FN_SEARCH, 32'h5555_5555, 8'd1);      // top entry, limit one
      send_word(FN_SEARCH, 32'h0000_0000, 8'd3);      // bottom entry just outside limit
      send_word(FN_SEARCH, 32'h0000_0000, 8'd4);      // limit reaches the bottom
      send_word(FN_SEARCH, 32'h5555_5555, 8'd0);      // zero limit never hits
      send_word(FN_SEARCH, 32'h0000_0000, LIM_MOST_NEG);
      send_word(FN_SEARCH, 32'h0000_0000, LIM_NONE);
      send_word(FN_SEARCH, 32'h0000_0000, 8'h7F);     // limit above the count
      send_word(FN_SEARCH, 32'h1234_5678, LIM_NONE);  // key not held
      send_word(FN_UNUSED, 32'h5555_5555, 8'd1);
      repeat (4) send_word(FN_POP, 32'hFFFF_FFFF, 8'hFF);
      send_word(FN_POP, 32'h0000_0000, 8'h00);
   endtask

   // fill to capacity, overflow, search the bottom, then drain past empty
   task automatic test_fill_and_drain();
      while (shadow_count < STACK_DEPTH) begin
         if ($urandom_range(7) == 0) send_random_op(0);
         else send_word(FN_PUSH, $urandom, 8'($urandom));
      end
      send_word(FN_PUSH, $urandom, 8'($urandom));
      send_word(FN_PUSH, 32'hFFFF_FFFF, 8'hFF);
      send_word(FN_SEARCH, shadow_stack[0], 8'd64);
      send_word(FN_SEARCH, shadow_stack[0], 8'd63);
      send_word(FN_SEARCH, shadow_stack[0], LIM_NONE);
      while (shadow_count > 0) begin
         if ($urandom_range(7) == 0) send_random_op(0);
         else send_word(FN_POP, $urandom, 8'($urandom));
      end
      send_word(FN_POP, $urandom, 8'($urandom));
   endtask

   // receiver stalls for a long stretch while requests keep coming, then a drain
   task automatic test_receiver_hold();
      hold_request = 250;
      repeat (24) send_random_op(50);
      wait_drained();
   endtask

   // both sides at full rate so words can issue on consecutive cycles
   task automatic test_back_to_back();
      src_idle_pct  = 0;
      sink_idle_pct = 0;
      repeat (70) send_random_op(35);
      src_idle_pct  = 30;
      sink_idle_pct = 30;
   endtask

   // long random mix that swings the stack between empty and full
   task automatic test_random_mix(int n);
      bit filling;
      filling = 1'b1;
      for (int i = 0; i < n; i++) begin
         if (shadow_count == STACK_DEPTH) filling = 1'b0;
         else if (shadow_count == 0) filling = 1'b1;
         else if ($urandom_range(59) == 0) filling = ~filling;
         send_random_op(filling ? 60 : 10);
      end
   endtask

   // receiver: random ready, or held low while a hold-off counts down
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= sink_idle_pct);
      end
   end

   // response checker: every accepted word against the oldest expectation
   always @(posedge clock) begin
      rsp_word_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("word with nothing pending", rsp_popped_value, 32'h0);
         end else begin
            w = pending_rsp.pop_front();
            if (rsp_popped_value !== w.popped)
               report_mismatch("popped_value", rsp_popped_value, w.popped);
            if (rsp_found !== w.found)
               report_mismatch("found", 32'(rsp_found), 32'(w.found));
            if (rsp_is_empty !== w.empty)
               report_mismatch("is_empty", 32'(rsp_is_empty), 32'(w.empty));
            if (rsp_entry_total !== w.total)
               report_mismatch("entry_total", 32'(rsp_entry_total), 32'(w.total));
            if (rsp_status !== w.status)
               report_mismatch("status", 32'(rsp_status), 32'(w.status));
         end
         rsp_seen++;
      end
   end

   // run limit, far above the slowest clean run
   initial begin
      #3_000_000;
      $display("tb: done, errors");
      $finish;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_stack();
      test_search_limits();
      test_fill_and_drain();
      test_receiver_hold();
      test_back_to_back();
      test_random_mix(190);
      // end of stimulus: wait for the tail, then a few quiet cycles
      req_valid <= 1'b0;
      for (int n = 0; n < 5000 && pending_rsp.size() != 0; n++) @(posedge clock);
      if (pending_rsp.size() != 0)
         report_mismatch("words never returned", pending_rsp.size(), 32'h0);
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
